@@ design/bat_pkg.sv @@
// breakpoint address table package: sizes, codes, beat and control types
`timescale 1ns / 1ps
package bat_pkg;

  localparam int MAX_BP  = 16;
  localparam int SLOT_W  = (MAX_BP > 1) ? $clog2(MAX_BP) : 1;
  localparam int COUNT_W = $clog2(MAX_BP + 1);
  localparam int WORD_W  = 30;

  typedef enum logic [1:0] {
    MODE_SET       = 2'd0,
    MODE_ERASE     = 2'd1,
    MODE_ERASE_ALL = 2'd2,
    MODE_CHECK     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       hit;
    logic [4:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } bat_cmd_t;

endpackage

@@ design/bat_ctrl.sv @@
// breakpoint address table controller: sequences capture, lookup and commit
`timescale 1ns / 1ps
module bat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output bat_pkg::bat_cmd_t cmd
);
  import bat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/bat_datapath.sv @@
// breakpoint address table datapath: entry store, match search, result register
`timescale 1ns / 1ps
module bat_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bat_pkg::bat_cmd_t cmd,
  input  bat_pkg::req_t     request,
  output logic              done,
  output bat_pkg::rsp_t     result
);
  import bat_pkg::*;

  req_t                 req;
  logic [MAX_BP-1:0]    valid;
  logic [MAX_BP-1:0]    valid_next;
  logic [WORD_W-1:0]    entry_word [MAX_BP];
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;

  logic [MAX_BP-1:0]    match_vec;
  logic [SLOT_W-1:0]    match_enc;
  logic [SLOT_W-1:0]    free_enc;
  logic                 match_found;
  logic [SLOT_W-1:0]    match_slot;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_slot;

  logic [WORD_W-1:0]    req_word;
  logic                 req_aligned;
  logic [2:0]           status;
  logic                 hit;
  logic                 word_we;
  logic [COUNT_W+4:0]   count_ext;

  assign req_word    = req.address[31:2];
  assign req_aligned = (req.address[1:0] == 2'b00);

  // one-hot match over all entries, lowest free slot
  always_comb begin
    match_enc = '0;
    free_enc  = '0;
    for (int i = 0; i < MAX_BP; i++) begin
      match_vec[i] = valid[i] && (entry_word[i] == req_word);
      if (match_vec[i]) begin
        match_enc = match_enc | SLOT_W'(i);
      end
    end
    for (int i = MAX_BP - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_enc = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    if (cmd.lookup) begin
      match_found <= |match_vec;
      match_slot  <= match_enc;
      free_found  <= ~&valid;
      free_slot   <= free_enc;
    end
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    status     = ST_OK;
    hit        = 1'b0;
    word_we    = 1'b0;
    case (req.mode)
      MODE_SET: begin
        if (match_found) begin
          status = ST_EXISTS;
        end else if (!free_found) begin
          status = ST_FULL;
        end else begin
          valid_next[free_slot] = 1'b1;
          count_next            = count + COUNT_W'(1);
          word_we               = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!(req_aligned && match_found)) begin
          status = ST_NOT_FOUND;
        end else begin
          valid_next[match_slot] = 1'b0;
          count_next             = count - COUNT_W'(1);
        end
      end
      MODE_ERASE_ALL: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else begin
          valid_next = '0;
          count_next = '0;
        end
      end
      default: begin
        hit = req_aligned && match_found;
      end
    endcase
  end

  assign count_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        valid <= valid_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && word_we) begin
      entry_word[free_slot] <= req_word;
    end
    if (cmd.commit) begin
      result.status      <= status;
      result.hit         <= hit;
      result.entry_count <= count_ext[4:0];
    end
  end

endmodule

@@ design/breakpoint_address_table_unit.sv @@
// breakpoint address table top level: controller plus datapath
// the result strobe done is registered from the commit state, which follows the lookup state
// a new request is taken only in idle, after the last one has passed capture, lookup and commit
// the lookup step compares all entries in parallel and registers the match
// done is high for exactly one cycle per request; the receiver cannot stall
// synchronous reset empties the table and returns the controller to idle
`timescale 1ns / 1ps
module breakpoint_address_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bat_pkg::req_t request,
  output logic          done,
  output bat_pkg::rsp_t result
);
  import bat_pkg::*;

  bat_cmd_t cmd;

  bat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bat_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

@@ design/bat_checker.sv @@
// breakpoint address table port checker and its bind
`timescale 1ns / 1ps
module bat_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input bat_pkg::rsp_t result
);
  import bat_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result beat right after accept");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result beat without work in flight");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> (result.status == ST_OK))
    else $error("hit with non-ok status");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (result.entry_count == 5'd0))
    else $error("empty status with nonzero count");

endmodule

bind breakpoint_address_table_unit bat_checker u_bat_checker (.*);

@@ bench/breakpoint_address_table_unit_test.sv @@
// testbench for the breakpoint address table: directed and random requests against a model
`timescale 1ns / 1ps
module breakpoint_address_table_unit_test;
  import bat_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;
  localparam int POOL_WORDS   = 24;
  localparam int RANDOM_BEATS = 650;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  request = '0;
  logic  busy;
  logic  done;
  rsp_t  result;

  breakpoint_address_table_unit uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // table model state
  logic        bp_valid [MAX_BP];
  logic [29:0] bp_word  [MAX_BP];
  int          bp_count;

  rsp_t        answer_q [$];
  logic [29:0] word_pool [POOL_WORDS];
  int          sender_idle_pct;
  int          mismatches;
  int          cycle_count;
  int          mode_beats [4];
  int          hits_seen;
  int          full_seen;

  function automatic rsp_t bp_table_update(req_t beat);
    rsp_t        r;
    logic [29:0] w;
    logic        aligned;
    int          found;
    int          free_slot;
    int          i;
    w = beat.address[31:2];
    aligned = (beat.address[1:0] == 2'b00);
    found = -1;
    free_slot = -1;
    for (i = 0; i < MAX_BP; i++) begin
      if (bp_valid[i] && bp_word[i] == w && found < 0) found = i;
      if (!bp_valid[i] && free_slot < 0) free_slot = i;
    end
    r = '0;
    r.status = ST_OK;
    case (beat.mode)
      MODE_SET: begin
        if (found >= 0) begin
          r.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          bp_valid[free_slot] = 1'b1;
          bp_word[free_slot] = w;
          bp_count++;
        end
      end
      MODE_ERASE: begin
        if (bp_count == 0) begin
          r.status = ST_EMPTY;
        end else if (!aligned || found < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          bp_valid[found] = 1'b0;
          bp_word[found] = '0;
          bp_count--;
        end
      end
      MODE_ERASE_ALL: begin
        if (bp_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < MAX_BP; i++) begin
            bp_valid[i] = 1'b0;
            bp_word[i] = '0;
          end
          bp_count = 0;
        end
      end
      default: begin
        r.hit = aligned && (found >= 0);
      end
    endcase
    r.entry_count = bp_count[4:0];
    return r;
  endfunction

  // one request beat, held until accepted, then an optional gap
  task automatic send_beat(input mode_e m, input logic [31:0] a);
    req_t beat;
    rsp_t want;
    beat.mode = m;
    beat.address = a;
    start <= 1'b1;
    request <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = bp_table_update(beat);
    answer_q.push_back(want);
    mode_beats[beat.mode]++;
    if (want.hit) hits_seen++;
    if (want.status == ST_FULL) full_seen++;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_table_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at cycle %0d: expected %0d, got %0d",
               field, cycle_count, want, got);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, answer_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst && done) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unrequested result status", -1, result.status);
      end else begin
        want = answer_q.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", want.status, result.status);
        if (result.hit !== want.hit)
          report_mismatch("hit", want.hit, result.hit);
        if (result.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, result.entry_count);
      end
    end
  end

  // empty table, address extremes and alignment handling
  task automatic test_empty_and_alignment();
    send_beat(MODE_ERASE, 32'h0000_0000);
    send_beat(MODE_ERASE_ALL, 32'h0000_0000);
    send_beat(MODE_CHECK, 32'h0000_0000);
    send_beat(MODE_SET, 32'hFFFF_FFFF);
    send_beat(MODE_CHECK, 32'hFFFF_FFFC);
    send_beat(MODE_CHECK, 32'hFFFF_FFFF);
    send_beat(MODE_SET, 32'hFFFF_FFFE);
    send_beat(MODE_ERASE, 32'hFFFF_FFFD);
    send_beat(MODE_ERASE, 32'h0000_0000);
    send_beat(MODE_ERASE, 32'hFFFF_FFFC);
    wait_table_quiet();
  endtask

  // fill every slot, then overflow, duplicate on full, erase and refill, clear
  task automatic test_full_table();
    int i;
    for (i = 0; i < MAX_BP; i++)
      send_beat(MODE_SET, {i[3:0], 26'h155_5555 ^ i[25:0], i[1:0]});
    send_beat(MODE_SET, 32'h0000_0100);
    send_beat(MODE_SET, {4'd0, 26'h155_5555, 2'b11});
    send_beat(MODE_ERASE, {4'd1, 26'h155_5554, 2'b00});
    send_beat(MODE_SET, 32'h0000_0000);
    send_beat(MODE_ERASE_ALL, 32'hFFFF_FFFF);
    send_beat(MODE_CHECK, 32'h0000_0000);
    wait_table_quiet();
  endtask

  // random requests drawn mostly from a small word pool so the table fills and hits
  task automatic test_random(input int beats, input int idle_pct);
    int          i;
    int          roll;
    mode_e       m;
    logic [31:0] a;
    sender_idle_pct = idle_pct;
    for (i = 0; i < beats; i++) begin
      roll = $urandom_range(99);
      if (roll < 42) m = MODE_SET;
      else if (roll < 60) m = MODE_ERASE;
      else if (roll < 63) m = MODE_ERASE_ALL;
      else m = MODE_CHECK;
      roll = $urandom_range(99);
      if (roll < 12) begin
        a = $urandom;
      end else begin
        a = {word_pool[$urandom_range(POOL_WORDS - 1)], 2'b00};
        if (m == MODE_SET || roll < 20) a[1:0] = 2'($urandom_range(3));
      end
      send_beat(m, a);
      if (i == beats / 2) wait_table_quiet();
    end
    wait_table_quiet();
  endtask

  initial begin
    int i;
    for (i = 0; i < MAX_BP; i++) begin
      bp_valid[i] = 1'b0;
      bp_word[i] = '0;
    end
    bp_count = 0;
    mismatches = 0;
    cycle_count = 0;
    hits_seen = 0;
    full_seen = 0;
    sender_idle_pct = 0;
    for (i = 0; i < 4; i++) mode_beats[i] = 0;
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (i = 2; i < POOL_WORDS; i++) word_pool[i] = 30'($urandom);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_alignment();
    test_full_table();
    test_random(RANDOM_BEATS, 30);
    test_random(RANDOM_BEATS, 86);
    test_random(RANDOM_BEATS, 0);

    wait_table_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += answer_q.size();

    $display("requests: %0d set, %0d erase, %0d erase-all, %0d check",
             mode_beats[MODE_SET], mode_beats[MODE_ERASE],
             mode_beats[MODE_ERASE_ALL], mode_beats[MODE_CHECK]);
    $display("check hits %0d, sets refused on a full table %0d, mismatches %0d",
             hits_seen, full_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bat_pkg.sv
design/bat_ctrl.sv
design/bat_datapath.sv
design/breakpoint_address_table_unit.sv
design/bat_checker.sv
bench/breakpoint_address_table_unit_test.sv
